// ===== hw/rtl/olte_pkg.sv =====
`timescale 1ns / 1ps

package olte_pkg;

    // Operation codes carried in the op field.
    localparam logic [3:0] OP_INS_HEAD = 4'd0;
    localparam logic [3:0] OP_INS_TAIL = 4'd1;
    localparam logic [3:0] OP_INS_AT   = 4'd2;
    localparam logic [3:0] OP_RM_HEAD  = 4'd3;
    localparam logic [3:0] OP_RM_TAIL  = 4'd4;
    localparam logic [3:0] OP_RM_AT    = 4'd5;
    localparam logic [3:0] OP_READ     = 4'd6;
    localparam logic [3:0] OP_REPLACE  = 4'd7;
    localparam logic [3:0] OP_EXISTS   = 4'd8;
    localparam logic [3:0] OP_EQUAL_AT = 4'd9;
    localparam logic [3:0] OP_SWAP     = 4'd10;
    localparam logic [3:0] OP_CLEAR    = 4'd11;

    // Status codes reported with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] value;
        logic [7:0]  position;
        logic [7:0]  other_position;
    } olte_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic        match;
        logic [4:0]  entry_count;
        logic        is_empty;
    } olte_out_t;

endpackage

// ===== hw/rtl/olte_ram.sv =====
`timescale 1ns / 1ps

module olte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ordered_list_table_engine.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake         Payload
// s_       in         s_valid/s_ready   olte_in_t  (op, value, position, other_position)
// m_       out        m_valid/m_ready   olte_out_t (status, read_data, match,
//                                                    entry_count, is_empty)
//
// One request is taken at a time. Overwrites, clears, tail removals and
// rejected requests go straight to the result. Reads, compares at an index,
// swaps, shifting inserts and removals, and searches first step through the
// entry store. The result becomes valid in the same cycle as the block is
// ready for the next request. The entry store has a single read port and a
// single write port, so one entry moves or is compared per cycle. Reset is
// synchronous and clears only the count and the control state; the entry store
// is never cleared. A stalled result is held in the output register, and the
// next request is taken once that result has been loaded.

module ordered_list_table_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olte_pkg::olte_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output olte_pkg::olte_out_t m_data
);

    import olte_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Width wide enough for both the 8-bit positions and the count.
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // The sequencer. SWEEP walks the store one entry per cycle; the swap takes
    // three states after the first read is issued on the transfer itself.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_SWAP_B,
        S_SWAP_C,
        S_SWAP_D,
        S_DONE
    } state_t;

    // What a sweep does with each entry read: move it up, move it down,
    // compare it with the held value, or return it.
    typedef enum logic [1:0] {
        M_UP,
        M_DOWN,
        M_SCAN,
        M_FETCH
    } mode_t;

    state_t                state_reg,   state_next;
    mode_t                 mode_reg,    mode_next;
    logic [IDX_W-1:0]      ptr_reg,     ptr_next;
    logic [CNT_W-1:0]      rem_reg,     rem_next;
    logic                  pend_reg,    pend_next;
    logic [IDX_W-1:0]      wr_addr_reg, wr_addr_next;
    logic [DATA_WIDTH-1:0] val_reg,     val_next;
    logic [IDX_W-1:0]      pos_reg,     pos_next;
    logic [IDX_W-1:0]      pos2_reg,    pos2_next;
    logic [DATA_WIDTH-1:0] tmp_reg,     tmp_next;
    logic [1:0]            status_reg,  status_next;
    logic [DATA_WIDTH-1:0] rdata_reg,   rdata_next;
    logic                  match_reg,   match_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic                  m_valid_reg, m_valid_next;
    olte_out_t             m_data_reg,  m_data_next;

    // Entry store ports.
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    // Request decode, widened so that positions and count compare directly.
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] pos2_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] ins_pos_ext;
    logic             is_full;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pos_ext  = CMP_W'(s_data.position);
    assign pos2_ext = CMP_W'(s_data.other_position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        unique case (s_data.op)
            OP_INS_HEAD: ins_pos_ext = '0;
            OP_INS_TAIL: ins_pos_ext = cnt_ext;
            default:     ins_pos_ext = pos_ext;
        endcase
    end

    olte_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        pend_next    = pend_reg;
        wr_addr_next = wr_addr_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        pos2_next    = pos2_reg;
        tmp_next     = tmp_reg;
        status_next  = status_reg;
        rdata_next   = rdata_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    // The request is judged against the count before the
                    // transfer; the count is updated at once, and any data
                    // movement follows in the sweep.
                    val_next    = DATA_WIDTH'(s_data.value);
                    pos_next    = IDX_W'(s_data.position);
                    pos2_next   = IDX_W'(s_data.other_position);
                    status_next = ST_OK;
                    rdata_next  = '0;
                    match_next  = 1'b0;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;

                    unique case (s_data.op)
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                            if (ins_pos_ext > cnt_ext) begin
                                status_next = ST_RANGE;
                            end else if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                mode_next  = M_UP;
                                pos_next   = IDX_W'(ins_pos_ext);
                                ptr_next   = IDX_W'(count_reg - CNT_W'(1));
                                rem_next   = CNT_W'(cnt_ext - ins_pos_ext);
                                state_next = S_SWEEP;
                            end
                        end
                        OP_RM_HEAD, OP_RM_TAIL: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                                if (s_data.op == OP_RM_HEAD) begin
                                    mode_next  = M_DOWN;
                                    ptr_next   = IDX_W'(1);
                                    rem_next   = count_reg - CNT_W'(1);
                                    state_next = S_SWEEP;
                                end
                            end
                        end
                        OP_RM_AT: begin
                            if (pos_ext >= cnt_ext) begin
                                status_next = ST_RANGE;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                                mode_next  = M_DOWN;
                                ptr_next   = IDX_W'(pos_ext + CMP_W'(1));
                                rem_next   = CNT_W'(cnt_ext - pos_ext - CMP_W'(1));
                                state_next = S_SWEEP;
                            end
                        end
                        OP_READ, OP_EQUAL_AT: begin
                            if (pos_ext >= cnt_ext) begin
                                status_next = ST_RANGE;
                            end else begin
                                mode_next  = (s_data.op == OP_READ) ? M_FETCH : M_SCAN;
                                ptr_next   = IDX_W'(s_data.position);
                                rem_next   = CNT_W'(1);
                                state_next = S_SWEEP;
                            end
                        end
                        OP_REPLACE: begin
                            if (pos_ext >= cnt_ext) begin
                                status_next = ST_RANGE;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = IDX_W'(s_data.position);
                                ram_wr_data = DATA_WIDTH'(s_data.value);
                            end
                        end
                        OP_EXISTS: begin
                            mode_next  = M_SCAN;
                            ptr_next   = '0;
                            rem_next   = count_reg;
                            state_next = S_SWEEP;
                        end
                        OP_SWAP: begin
                            if ((pos_ext >= cnt_ext) || (pos2_ext >= cnt_ext)) begin
                                status_next = ST_RANGE;
                            end else if (pos_ext != pos2_ext) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = IDX_W'(s_data.position);
                                state_next  = S_SWAP_B;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                // Data read in the previous cycle is used now, while the next
                // entry is read: one entry per cycle.
                if (pend_reg) begin
                    unique case (mode_reg)
                        M_UP, M_DOWN: begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = wr_addr_reg;
                            ram_wr_data = ram_rd_data;
                        end
                        M_SCAN: begin
                            if (ram_rd_data == val_reg) begin
                                match_next = 1'b1;
                            end
                        end
                        M_FETCH: begin
                            rdata_next = ram_rd_data;
                        end
                    endcase
                end

                if (rem_reg != '0) begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = ptr_reg;
                    pend_next    = 1'b1;
                    rem_next     = rem_reg - CNT_W'(1);
                    wr_addr_next = (mode_reg == M_UP) ? ptr_reg + IDX_W'(1)
                                                      : ptr_reg - IDX_W'(1);
                    ptr_next     = (mode_reg == M_UP) ? ptr_reg - IDX_W'(1)
                                                      : ptr_reg + IDX_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        // The gap is open: the new entry goes in.
                        if (mode_reg == M_UP) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = pos_reg;
                            ram_wr_data = val_reg;
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_SWAP_B: begin
                tmp_next    = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = pos2_reg;
                state_next  = S_SWAP_C;
            end

            S_SWAP_C: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = ram_rd_data;
                state_next  = S_SWAP_D;
            end

            S_SWAP_D: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos2_reg;
                ram_wr_data = tmp_reg;
                state_next  = S_DONE;
            end

            S_DONE: begin
                // The result waits here only while the output register still
                // holds an earlier result that has not been taken.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.read_data   = 32'(rdata_reg);
                    m_data_next.match       = match_reg;
                    m_data_next.entry_count = 5'(count_reg);
                    m_data_next.is_empty    = (count_reg == '0);
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        ptr_reg     <= ptr_next;
        rem_reg     <= rem_next;
        wr_addr_reg <= wr_addr_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        pos2_reg    <= pos2_next;
        tmp_reg     <= tmp_next;
        status_reg  <= status_next;
        rdata_reg   <= rdata_next;
        match_reg   <= match_next;
        m_data_reg  <= m_data_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/olte_checker.sv =====
`timescale 1ns / 1ps

module olte_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input olte_pkg::olte_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input olte_pkg::olte_out_t m_data
);

    import olte_pkg::*;

    // Only one request is in flight: after a transfer the input closes.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open after a transfer");

    // A result that has not been taken stays unchanged.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // A rejected request returns neither data nor a match.
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_OK)) |->
            ((m_data.read_data == '0) && !m_data.match))
        else $error("rejected request returned data or match");

    // The empty flag agrees with the count.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_empty) |-> (m_data.entry_count == '0))
        else $error("empty flag set with entries present");

    // An empty list never reports a full status.
    a_empty_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_empty) |-> (m_data.status != ST_FULL))
        else $error("full status on an empty list");

endmodule

bind ordered_list_table_engine olte_checker u_olte_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/tb_ordered_list_table_engine.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the ordered list engine.
//
// The bench keeps its own copy of the list and its count, and updates that
// copy at each accepted request transfer. The result it works out is queued,
// and every result transfer from the block is checked against the oldest
// queued result, one field at a time. A short table of directed requests comes
// first. Where a row's result is plain (empty list, bounds, full list, clear),
// the table holds that result and it is checked as typed. Random requests
// follow in phases with different idling on the two channels.
module tb_ordered_list_table_engine;

    import olte_pkg::*;

    localparam int DEPTH           = 16;
    localparam int DATA_WIDTH      = 32;
    localparam int RESET_CYCLES    = 11;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int RANDOM_PHASES   = 8;
    localparam int HOLD_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 40;

    // Op codes twelve to fifteen are unused. The block must treat them as a
    // request that changes nothing.
    localparam logic [3:0] OP_SPARE = 4'd15;

    // One row of the directed table. The row is sent 'copies' times, and the
    // value goes up by one on each copy. When 'typed' is set, the result
    // written in the row is checked in place of the predicted one.
    typedef struct packed {
        olte_in_t   req;
        logic [4:0] copies;
        logic       typed;
        olte_out_t  want;
    } dir_row_t;

    localparam olte_out_t NO_CHECK      = '0;
    localparam int        DIRECTED_ROWS = 26;

    // The directed table follows the list from empty, to three entries, to
    // full, and back to empty again.
    dir_row_t directed_plan [DIRECTED_ROWS] = '{
        // Requests on an empty list: both removals, a search, a read, and an
        // insert at an index past the end.
        '{'{OP_RM_HEAD,  32'h0000_0000, 0, 0},   1, 1'b1, '{ST_EMPTY, 0, 0, 0, 1}},
        '{'{OP_RM_TAIL,  32'h0000_0000, 0, 0},   1, 1'b1, '{ST_EMPTY, 0, 0, 0, 1}},
        '{'{OP_EXISTS,   32'h0000_0000, 0, 0},   1, 1'b1, '{ST_OK,    0, 0, 0, 1}},
        '{'{OP_READ,     32'h0000_0000, 0, 0},   1, 1'b1, '{ST_RANGE, 0, 0, 0, 1}},
        '{'{OP_INS_AT,   32'h0000_0001, 1, 0},   1, 1'b1, '{ST_RANGE, 0, 0, 0, 1}},
        // Build the list up to three entries: all ones, a pattern, then zero.
        '{'{OP_INS_HEAD, 32'hffff_ffff, 0, 0},   1, 1'b1, '{ST_OK,    0, 0, 1, 0}},
        '{'{OP_INS_TAIL, 32'h0000_0000, 0, 0},   1, 1'b1, '{ST_OK,    0, 0, 2, 0}},
        '{'{OP_INS_AT,   32'ha5a5_a5a5, 1, 0},   1, 1'b0, NO_CHECK},
        '{'{OP_READ,     32'h0000_0000, 0, 0},   1, 1'b1,
          '{ST_OK, 32'hffff_ffff, 0, 3, 0}},
        '{'{OP_EQUAL_AT, 32'h0000_0000, 2, 0},   1, 1'b1, '{ST_OK,    0, 1, 3, 0}},
        '{'{OP_REPLACE,  32'h0000_0005, 255, 0}, 1, 1'b1, '{ST_RANGE, 0, 0, 3, 0}},
        '{'{OP_SWAP,     32'h0000_0000, 0, 2},   1, 1'b0, NO_CHECK},
        '{'{OP_SWAP,     32'h0000_0000, 1, 1},   1, 1'b1, '{ST_OK,    0, 0, 3, 0}},
        '{'{OP_SWAP,     32'h0000_0000, 0, 255}, 1, 1'b1, '{ST_RANGE, 0, 0, 3, 0}},
        '{'{OP_EXISTS,   32'hffff_ffff, 0, 0},   1, 1'b0, NO_CHECK},
        '{'{OP_RM_AT,    32'h0000_0000, 1, 0},   1, 1'b0, NO_CHECK},
        '{'{OP_SPARE,    32'hffff_ffff, 255, 255}, 1, 1'b1, '{ST_OK,  0, 0, 2, 0}},
        '{'{OP_REPLACE,  32'h5a5a_5a5a, 1, 0},   1, 1'b0, NO_CHECK},
        // Fill to capacity. After that an insert reports full, except at an
        // index past the end, where the bounds check comes first.
        '{'{OP_INS_TAIL, 32'h8000_0001, 0, 0},  14, 1'b0, NO_CHECK},
        '{'{OP_INS_HEAD, 32'h0000_0003, 0, 0},   1, 1'b1, '{ST_FULL,  0, 0, 16, 0}},
        '{'{OP_INS_AT,   32'h0000_0003, 17, 0},  1, 1'b1, '{ST_RANGE, 0, 0, 16, 0}},
        '{'{OP_INS_AT,   32'h0000_0003, 16, 0},  1, 1'b1, '{ST_FULL,  0, 0, 16, 0}},
        '{'{OP_RM_AT,    32'h0000_0000, 15, 0},  1, 1'b0, NO_CHECK},
        '{'{OP_RM_HEAD,  32'h0000_0000, 0, 0},   1, 1'b0, NO_CHECK},
        '{'{OP_CLEAR,    32'h0000_0000, 0, 0},   1, 1'b1, '{ST_OK,    0, 0, 0, 1}},
        '{'{OP_READ,     32'h0000_0000, 0, 0},   1, 1'b1, '{ST_RANGE, 0, 0, 0, 1}}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    olte_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    olte_out_t m_data;

    // The bench's own copy of the list.
    logic [DATA_WIDTH-1:0] list_mem [DEPTH];
    int unsigned           list_count;

    olte_out_t results_due [$];
    olte_out_t due_head;

    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned status_seen [4];
    int unsigned stall_cycles;

    // Idling levels, in percent, for the phase in progress.
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;

    // The main thread raises hold_req_cnt to ask for a long receiver hold-off.
    // The receiver process counts the hold-off itself.
    int unsigned hold_req_cnt;
    int unsigned hold_seen_cnt;
    int unsigned hold_left;

    ordered_list_table_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one request to the bench's list and returns its result. Entries
    // shift up on an insert and down on a removal, as they do in the block.
    function automatic olte_out_t apply_request(input olte_in_t req);
        olte_out_t             res;
        int unsigned           at;
        int unsigned           i;
        logic [DATA_WIDTH-1:0] held;
        res = '0;
        res.status = ST_OK;
        case (req.op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                if (req.op == OP_INS_HEAD) begin
                    at = 0;
                end else if (req.op == OP_INS_TAIL) begin
                    at = list_count;
                end else begin
                    at = 32'(req.position);
                end
                if (at > list_count) begin
                    res.status = ST_RANGE;
                end else if (list_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_count; i > at; i--) begin
                        list_mem[i] = list_mem[i-1];
                    end
                    list_mem[at] = req.value[DATA_WIDTH-1:0];
                    list_count++;
                end
            end
            OP_RM_HEAD, OP_RM_TAIL: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (req.op == OP_RM_HEAD) begin
                        for (i = 0; i + 1 < list_count; i++) begin
                            list_mem[i] = list_mem[i+1];
                        end
                    end
                    list_count--;
                end
            end
            OP_RM_AT: begin
                if (req.position >= list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = 32'(req.position); i + 1 < list_count; i++) begin
                        list_mem[i] = list_mem[i+1];
                    end
                    list_count--;
                end
            end
            OP_READ, OP_REPLACE, OP_EQUAL_AT: begin
                if (req.position >= list_count) begin
                    res.status = ST_RANGE;
                end else if (req.op == OP_READ) begin
                    res.read_data = list_mem[req.position];
                end else if (req.op == OP_REPLACE) begin
                    list_mem[req.position] = req.value[DATA_WIDTH-1:0];
                end else begin
                    res.match = (list_mem[req.position] == req.value[DATA_WIDTH-1:0]);
                end
            end
            OP_EXISTS: begin
                for (i = 0; i < list_count; i++) begin
                    if (list_mem[i] == req.value[DATA_WIDTH-1:0]) begin
                        res.match = 1'b1;
                    end
                end
            end
            OP_SWAP: begin
                if (req.position >= list_count || req.other_position >= list_count) begin
                    res.status = ST_RANGE;
                end else if (req.position != req.other_position) begin
                    held = list_mem[req.position];
                    list_mem[req.position] = list_mem[req.other_position];
                    list_mem[req.other_position] = held;
                end
            end
            OP_CLEAR: begin
                list_count = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = list_count[4:0];
        res.is_empty = (list_count == 0);
        return res;
    endfunction

    // Builds one random request. Most requests are well formed: the indexes
    // fall in or just past the list, and the searched value is often an entry
    // that the list holds. grow_pct sets how often a shifting request is an
    // insert, so that a phase can push the list to full and then drain it.
    // The rest is noise, with every op code and indexes across the whole range.
    function automatic olte_in_t make_request(input int unsigned grow_pct);
        olte_in_t    req;
        int unsigned pick;
        req.value = $urandom;
        req.position = 8'($urandom_range(0, 255));
        req.other_position = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 8) begin
            req.op = 4'($urandom_range(0, 15));
            return req;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            if ($urandom_range(0, 99) < grow_pct) begin
                req.op = 4'($urandom_range(OP_INS_HEAD, OP_INS_AT));
            end else begin
                req.op = 4'($urandom_range(OP_RM_HEAD, OP_RM_AT));
            end
        end else if (pick < 99) begin
            case ($urandom_range(0, 4))
                0:       req.op = OP_READ;
                1:       req.op = OP_REPLACE;
                2:       req.op = OP_EXISTS;
                3:       req.op = OP_EQUAL_AT;
                default: req.op = OP_SWAP;
            endcase
        end else begin
            req.op = OP_CLEAR;
        end
        if (list_count > 0 && $urandom_range(0, 1) == 1) begin
            req.value = list_mem[$urandom_range(0, list_count - 1)];
        end
        if ($urandom_range(0, 9) != 0) begin
            req.position = 8'($urandom_range(0, list_count));
        end
        if ($urandom_range(0, 9) != 0) begin
            req.other_position = 8'($urandom_range(0, list_count));
        end
        return req;
    endfunction

    // Offers one request and waits for its transfer. The sender may idle at
    // random before the request. The result is queued at the clock edge that
    // takes the request.
    task automatic send_request(input olte_in_t req, input logic typed,
                                input olte_out_t want);
        olte_out_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(req);
        results_due.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Lowers valid and waits until every queued result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 54; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 54; end
            default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            if (error_count < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want_v, got_v);
            end
            error_count++;
        end
    endtask

    // Receiver. When the main thread asks for a hold-off, ready stays low for
    // a long stretch. The result register then fills, and the block stalls
    // its input while the sender keeps offering.
    always @(negedge aclk) begin
        if (hold_seen_cnt != hold_req_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Result checker. Each result transfer is compared with the oldest result
    // in the queue.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            status_seen[m_data.status]++;
            if (results_due.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("%0t: result with none expected, expected nothing, actual %0h",
                             $time, m_data);
                end
                error_count++;
            end else begin
                due_head = results_due.pop_front();
                results_checked++;
                check_field("status",      32'(due_head.status),      32'(m_data.status));
                check_field("read_data",   due_head.read_data,        m_data.read_data);
                check_field("match",       32'(due_head.match),       32'(m_data.match));
                check_field("entry_count", 32'(due_head.entry_count),
                            32'(m_data.entry_count));
                check_field("is_empty",    32'(due_head.is_empty),    32'(m_data.is_empty));
            end
        end
    end

    // Watchdog. It counts clock edges at which neither channel has a
    // transfer, and ends the run if the count reaches the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Counters written by the checker, watchdog and receiver processes start
    // at zero as two-state variables and are not touched here.
    initial begin
        olte_in_t    req;
        int unsigned row;
        int unsigned copy;
        int unsigned phase;
        int unsigned k;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        list_count    = 0;
        requests_sent = 0;
        hold_req_cnt  = 0;
        set_idling(0);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, sent with no idling on either side.
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            for (copy = 0; copy < directed_plan[row].copies; copy++) begin
                req = directed_plan[row].req;
                req.value = req.value + copy;
                send_request(req, directed_plan[row].typed, directed_plan[row].want);
            end
        end
        drain_results();

        // Random part. Each phase first grows the list and then drains it.
        // The sender waits for all results at the end of every phase. In the
        // first phase the receiver holds off for a long stretch while
        // requests keep arriving.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idling(phase % 4);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 0 && k == 20) begin
                    hold_req_cnt++;
                end
                send_request(make_request(k < ITEMS_PER_PHASE / 2 ? 80 : 25), 1'b0,
                             NO_CHECK);
            end
            drain_results();
        end

        // Allow time for a stray result to turn up after the last one expected.
        repeat (DEPTH + 8) @(posedge aclk);

        $display("Sent %0d requests over %0d idling phases, checked %0d results.",
                 requests_sent, RANDOM_PHASES + 1, results_checked);
        $display("Statuses seen: ok %0d, range %0d, empty %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
                 status_seen[ST_FULL]);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/olte_pkg.sv
hw/rtl/olte_ram.sv
hw/rtl/ordered_list_table_engine.sv
hw/rtl/olte_checker.sv
verif/tb_ordered_list_table_engine.sv
